### hw/rtl/mot_pkg.sv
// Shared package for the millisecond one-shot timer.
// Holds mode codes, tick width, default unit length and the per-transaction record.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mot_pkg;

  // Width of the free-running tick counter and of unit counts
  localparam int TICK_W = 32;

  // Default ticks in one unit
  localparam int unsigned TICKS_PER_UNIT_DEF = 1000;

  // Transaction modes
  localparam logic [1:0] MODE_POLL  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // Result of the state update, before the overrun divide
  typedef struct packed {
    logic              expired;
    logic              running;
    logic              ov_plus1;   // add one unit: run was started with zero units
    logic [TICK_W-1:0] ov_ticks;   // ticks past the deadline, divided downstream
  } tmr_rec_t;

endpackage

`default_nettype wire

### hw/rtl/mot_prep.sv
// Input register stage of the timer.
// Captures each transaction and forms the start load (total ticks of the wait).
// Depends on mot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mot_prep #(
  parameter int unsigned TICKS_PER_UNIT = mot_pkg::TICKS_PER_UNIT_DEF,
  localparam int LOAD_W = mot_pkg::TICK_W + $clog2(TICKS_PER_UNIT)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                mode,
  input  wire logic [mot_pkg::TICK_W-1:0] wait_units,
  input  wire logic [mot_pkg::TICK_W-1:0] uptime_ticks,
  input  wire logic                      ready_dn,
  output logic                           s_valid,
  output logic [1:0]                     s_mode,
  output logic [mot_pkg::TICK_W-1:0]     s_now,
  output logic [LOAD_W-1:0]              s_load,
  output logic                           s_zero
);

  logic              ready;
  logic              accept;
  logic              zero_req;
  logic [LOAD_W-1:0] load_next;

  assign ready    = !s_valid || ready_dn;
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  // Total ticks to the deadline; a zero-unit wait still runs one unit
  assign zero_req  = (wait_units == '0);
  assign load_next = zero_req ? LOAD_W'(TICKS_PER_UNIT)
                              : LOAD_W'(wait_units) * LOAD_W'(TICKS_PER_UNIT);

  // Hold the stage valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (ready) begin
      s_valid <= in_valid;
    end
  end

  // Capture the transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s_mode <= mode;
      s_now  <= uptime_ticks;
      s_load <= load_next;
      s_zero <= zero_req;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mot_state.sv
// Timer state loop: active flag, ticks left to the deadline, last sample, overrun.
// One compare and subtract on the remaining ticks per poll. Depends on mot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mot_state #(
  parameter int unsigned TICKS_PER_UNIT = mot_pkg::TICKS_PER_UNIT_DEF,
  localparam int LOAD_W = mot_pkg::TICK_W + $clog2(TICKS_PER_UNIT)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_valid,
  input  wire logic [1:0]                 s_mode,
  input  wire logic [mot_pkg::TICK_W-1:0] s_now,
  input  wire logic [LOAD_W-1:0]          s_load,
  input  wire logic                       s_zero,
  output logic                            ready_up,
  output logic                            r_valid,
  output mot_pkg::tmr_rec_t               r_rec,
  input  wire logic                       ready_dn
);

  logic                       ready;
  logic                       take;

  logic                       active;
  logic                       active_next;
  logic                       units_zero;
  logic                       units_zero_next;
  logic [LOAD_W-1:0]          left;
  logic [LOAD_W-1:0]          left_next;
  logic [mot_pkg::TICK_W-1:0] last;
  logic [mot_pkg::TICK_W-1:0] last_next;
  logic [mot_pkg::TICK_W-1:0] ov_ticks;
  logic [mot_pkg::TICK_W-1:0] ov_ticks_next;
  logic                       ov_plus1;
  logic                       ov_plus1_next;
  logic                       expired_now;

  logic [mot_pkg::TICK_W-1:0] elapsed;
  logic [LOAD_W-1:0]          elapsed_w;
  logic                       reached;

  assign ready    = !r_valid || ready_dn;
  assign ready_up = ready;
  assign take     = s_valid && ready;

  // Elapsed ticks wrap modulo the counter width
  assign elapsed   = s_now - last;
  assign elapsed_w = LOAD_W'(elapsed);
  assign reached   = (elapsed_w >= left);

  // Work out the next state for this transaction
  always_comb begin
    active_next     = active;
    units_zero_next = units_zero;
    left_next       = left;
    last_next       = last;
    ov_ticks_next   = ov_ticks;
    ov_plus1_next   = ov_plus1;
    expired_now     = 1'b0;
    case (s_mode)
      mot_pkg::MODE_POLL: begin
        if (active) begin
          if (reached) begin
            // Deadline passed: stop and keep the excess for the overrun divide
            active_next   = 1'b0;
            ov_ticks_next = elapsed - left[mot_pkg::TICK_W-1:0];
            ov_plus1_next = units_zero;
            expired_now   = 1'b1;
          end else begin
            left_next = left - elapsed_w;
            last_next = s_now;
          end
        end
      end
      mot_pkg::MODE_START: begin
        active_next     = 1'b1;
        units_zero_next = s_zero;
        left_next       = s_load;
        last_next       = s_now;
        ov_ticks_next   = '0;
        ov_plus1_next   = 1'b0;
      end
      mot_pkg::MODE_STOP: begin
        active_next   = 1'b0;
        ov_ticks_next = '0;
        ov_plus1_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Advance the timer state once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      units_zero <= 1'b0;
      left       <= '0;
      last       <= '0;
      ov_ticks   <= '0;
      ov_plus1   <= 1'b0;
    end else if (take) begin
      active     <= active_next;
      units_zero <= units_zero_next;
      left       <= left_next;
      last       <= last_next;
      ov_ticks   <= ov_ticks_next;
      ov_plus1   <= ov_plus1_next;
    end
  end

  // Hold the result valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (ready) begin
      r_valid <= s_valid;
    end
  end

  // Register the result record
  always_ff @(posedge clk) begin
    if (take) begin
      r_rec.expired  <= expired_now;
      r_rec.running  <= active_next;
      r_rec.ov_plus1 <= ov_plus1_next;
      r_rec.ov_ticks <= ov_ticks_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mot_div.sv
// Overrun divide and output register: excess ticks over the unit length.
// Reciprocal multiply, back multiply, then one correction step. Depends on mot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mot_div #(
  parameter int unsigned TICKS_PER_UNIT = mot_pkg::TICKS_PER_UNIT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       r_valid,
  input  wire mot_pkg::tmr_rec_t          r_rec,
  output logic                            ready_up,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            expired,
  output logic                            running,
  output logic [mot_pkg::TICK_W-1:0]      overrun_units
);

  localparam int TW = mot_pkg::TICK_W;
  localparam logic [2*TW-1:0] ONE_SHL = (2*TW)'(1) << TW;
  localparam logic [TW-1:0]   RECIP   = TW'(ONE_SHL / (2*TW)'(TICKS_PER_UNIT));
  localparam logic [TW-1:0]   UNIT    = TW'(TICKS_PER_UNIT);

  logic              o_ready;
  logic              b_ready;
  logic              a_ready;

  logic              a_valid;
  mot_pkg::tmr_rec_t a_rec;
  logic [TW-1:0]     a_q0;
  logic [2*TW-1:0]   a_prod;

  logic              b_valid;
  mot_pkg::tmr_rec_t b_rec;
  logic [TW-1:0]     b_q0;
  logic [TW-1:0]     b_back;

  logic [TW-1:0]     rem;
  logic [TW-1:0]     quot;

  assign o_ready  = !out_valid || !out_stall;
  assign b_ready  = !b_valid || o_ready;
  assign a_ready  = !a_valid || b_ready;
  assign ready_up = a_ready;

  // Estimate the quotient; it is low by at most one
  assign a_prod = (2*TW)'(r_rec.ov_ticks) * (2*TW)'(RECIP);

  // Finish the remainder and correct the estimate
  assign rem  = b_rec.ov_ticks - b_back;
  assign quot = b_q0 + TW'(rem >= UNIT) + TW'(b_rec.ov_plus1);

  // Hold the stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= r_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (o_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  // Advance the payload through the divide stages
  always_ff @(posedge clk) begin
    if (a_ready && r_valid) begin
      a_rec <= r_rec;
      a_q0  <= a_prod[2*TW-1:TW];
    end
    if (b_ready && a_valid) begin
      b_rec  <= a_rec;
      b_q0   <= a_q0;
      b_back <= TW'(a_q0 * UNIT);
    end
    if (o_ready && b_valid) begin
      expired       <= b_rec.expired;
      running       <= b_rec.running;
      overrun_units <= quot;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/millisecond_oneshot_timer_top.sv
// Top level of the millisecond one-shot timer.
// Instantiates mot_prep, mot_state and mot_div; depends on mot_pkg.
//
//   channel   dir  handshake             payload
//   input     in   in_valid / in_stall   mode, wait_units, uptime_ticks
//   result    out  out_valid / out_stall expired, running, overrun_units
//
// One transaction per cycle unless out_stall holds the pipeline back.
// The rate is set by the state register loop: one compare and subtract on the
// remaining ticks per poll. Divide stages a and b and the output register follow.
// Synchronous reset clears the timer state and all stage valid bits.
// A stall holds only the stages that are full; empty stages keep filling, so
// input is taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module millisecond_oneshot_timer_top #(
  parameter int unsigned TICKS_PER_UNIT = mot_pkg::TICKS_PER_UNIT_DEF,
  localparam int LOAD_W = mot_pkg::TICK_W + $clog2(TICKS_PER_UNIT)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 mode,
  input  wire logic [mot_pkg::TICK_W-1:0] wait_units,
  input  wire logic [mot_pkg::TICK_W-1:0] uptime_ticks,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            expired,
  output logic                            running,
  output logic [mot_pkg::TICK_W-1:0]      overrun_units
);

  logic                       s_valid;
  logic [1:0]                 s_mode;
  logic [mot_pkg::TICK_W-1:0] s_now;
  logic [LOAD_W-1:0]          s_load;
  logic                       s_zero;
  logic                       state_ready;
  logic                       r_valid;
  mot_pkg::tmr_rec_t          r_rec;
  logic                       div_ready;

  // Capture transactions
  mot_prep #(.TICKS_PER_UNIT(TICKS_PER_UNIT)) u_prep (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .wait_units   (wait_units),
    .uptime_ticks (uptime_ticks),
    .ready_dn     (state_ready),
    .s_valid      (s_valid),
    .s_mode       (s_mode),
    .s_now        (s_now),
    .s_load       (s_load),
    .s_zero       (s_zero)
  );

  // Update the timer
  mot_state #(.TICKS_PER_UNIT(TICKS_PER_UNIT)) u_state (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_valid),
    .s_mode   (s_mode),
    .s_now    (s_now),
    .s_load   (s_load),
    .s_zero   (s_zero),
    .ready_up (state_ready),
    .r_valid  (r_valid),
    .r_rec    (r_rec),
    .ready_dn (div_ready)
  );

  // Divide the overrun and drive the result
  mot_div #(.TICKS_PER_UNIT(TICKS_PER_UNIT)) u_div (
    .clk           (clk),
    .rst           (rst),
    .r_valid       (r_valid),
    .r_rec         (r_rec),
    .ready_up      (div_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .expired       (expired),
    .running       (running),
    .overrun_units (overrun_units)
  );

endmodule

`default_nettype wire

### hw/rtl/mot_checker.sv
// Port-level checks for the millisecond one-shot timer, bound to the top level.
// Sees only the top-level ports; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module mot_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  mode,
  input wire logic [31:0] wait_units,
  input wire logic [31:0] uptime_ticks,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        expired,
  input wire logic        running,
  input wire logic [31:0] overrun_units
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // Keep a stalled payload steady
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(expired) && $stable(running) && $stable(overrun_units))
    else $error("stalled result payload changed");

  // An expiring poll leaves the timer stopped
  a_exp_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(expired && running))
    else $error("result reports expiry while still running");

  // Flush results on reset
  a_rst_flush: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind millisecond_oneshot_timer_top mot_checker u_mot_checker (.*);

`default_nettype wire
